// ===== hdl/mrq_pkg.sv =====
// ----------------------------------------------------------------------------
// Message ring queue package
// Request and status codes and default sizes shared by the queue modules.
// ----------------------------------------------------------------------------
package mrq_pkg;

   // Default built depth of the slot ring and width of one message word.
   localparam int QUEUE_DEPTH_DEF   = 16;
   localparam int MESSAGE_WIDTH_DEF = 32;

   // Request codes carried on req_type.
   typedef enum logic [1:0] {
      REQ_SEND = 2'd0,
      REQ_JAM  = 2'd1,
      REQ_RECV = 2'd2
   } req_code_type;

   // Status codes returned on rsp_status.
   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_code_type;

endpackage

// ===== hdl/mrq_slot_ram.sv =====
// ----------------------------------------------------------------------------
// Message ring slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mrq_slot_ram #(
   parameter int DEPTH = mrq_pkg::QUEUE_DEPTH_DEF,
   parameter int WIDTH = mrq_pkg::MESSAGE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read, so a stalled result keeps its word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/message_ring_queue_with_jam_top.sv =====
// ----------------------------------------------------------------------------
// Message ring queue with head insert
// A ring of message slots serving send (tail write), jam (head insert) and
// receive (head read) requests, with a run-time capacity register.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Carries
//   --------+-----------+----------------------+----------------------------
//   req_    | in        | req_valid/req_stall  | req_type, req_message
//   rsp_    | out       | rsp_valid/rsp_stall  | rsp_status, rsp_read_message,
//           |           |                      | rsp_fill_count
//   csr_    | in        | csr_valid/csr_ready  | csr_capacity
//
// One transaction is taken per cycle when the result side keeps up. A request
// lands in an input register, is processed from there against the head index
// and fill count once the result register is free, and its result is
// registered in the result register. The head and count update, made as a
// request leaves the input register, sets the rate. Synchronous reset empties
// the queue and sets capacity to the built depth; slot contents are not
// cleared. A stalled result holds; the input register still takes one more
// transaction behind it before req_stall rises.
// ----------------------------------------------------------------------------
module message_ring_queue_with_jam_top #(
   parameter int QUEUE_DEPTH   = mrq_pkg::QUEUE_DEPTH_DEF,
   parameter int MESSAGE_WIDTH = mrq_pkg::MESSAGE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_type,
   input  logic [MESSAGE_WIDTH-1:0]         req_message,
   // Result channel.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [MESSAGE_WIDTH-1:0]         rsp_read_message,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] rsp_fill_count,
   // Capacity register write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0] csr_capacity
);

   // CNT_W holds any fill count up to the built depth; IDX_W addresses a slot.
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   // Input register.
   logic                     in_valid_ff, in_valid_in;
   logic [1:0]               in_type_ff;
   logic [MESSAGE_WIDTH-1:0] in_msg_ff;

   // Queue state.
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] capacity_ff;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   mrq_pkg::status_code_type      status_ff, status_in;
   logic [CNT_W-1:0]              fill_ff;
   logic                          rd_sel_ff, rd_sel_in;
   logic [MESSAGE_WIDTH-1:0]      ram_rd_data;

   // Handshake and datapath control.
   logic             req_accept;
   logic             csr_write;
   logic             out_free;
   logic             advance;
   logic [CNT_W-1:0] cap_eff;
   logic             full;
   logic             empty;
   logic [CNT_W:0]   tail_sum;
   logic [CNT_W:0]   tail_pos;
   logic [CNT_W-1:0] head_ext;
   logic [CNT_W-1:0] head_dec;
   logic [CNT_W-1:0] head_inc;
   logic [CNT_W-1:0] head_fwd;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_en;

   // The result register frees up when it is empty or being taken this cycle.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   // Capacity writes wait for the input register to drain, so a write never
   // lands in the same cycle as a head and count update.
   assign csr_ready  = !in_valid_ff;
   assign csr_write  = csr_valid && csr_ready;

   // A capacity of zero behaves as one; anything above the built depth is
   // clamped to the built depth.
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = ONE_CNT;
      end else if (capacity_ff > DEPTH_CNT) begin
         cap_eff = DEPTH_CNT;
      end else begin
         cap_eff = capacity_ff;
      end
   end

   assign full  = count_ff >= cap_eff;
   assign empty = count_ff == '0;

   // The head stays below the capacity and the count at or below it, so each
   // wrap below is at most one subtraction of the capacity.
   assign head_ext = CNT_W'(head_ff);
   assign tail_sum = {1'b0, head_ext} + {1'b0, count_ff};
   assign tail_pos = (tail_sum >= {1'b0, cap_eff}) ? tail_sum - {1'b0, cap_eff} : tail_sum;
   assign head_dec = (head_ff == '0) ? cap_eff - ONE_CNT : head_ext - ONE_CNT;
   assign head_inc = head_ext + ONE_CNT;
   assign head_fwd = (head_inc >= cap_eff) ? head_inc - cap_eff : head_inc;

   // Request decode: next head and count, memory access and status.
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = mrq_pkg::STAT_DONE;
      rd_sel_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = tail_pos[IDX_W-1:0];
      rd_en     = 1'b0;
      unique case (mrq_pkg::req_code_type'(in_type_ff))
         mrq_pkg::REQ_SEND: begin
            if (full) begin
               status_in = mrq_pkg::STAT_FULL;
            end else begin
               wr_en    = advance;
               count_in = count_ff + ONE_CNT;
            end
         end
         mrq_pkg::REQ_JAM: begin
            if (full) begin
               status_in = mrq_pkg::STAT_FULL;
            end else begin
               wr_en    = advance;
               wr_addr  = head_dec[IDX_W-1:0];
               head_in  = head_dec[IDX_W-1:0];
               count_in = count_ff + ONE_CNT;
            end
         end
         mrq_pkg::REQ_RECV: begin
            if (empty) begin
               status_in = mrq_pkg::STAT_EMPTY;
            end else begin
               rd_en     = advance;
               rd_sel_in = 1'b1;
               head_in   = head_fwd[IDX_W-1:0];
               count_in  = count_ff - ONE_CNT;
            end
         end
         default: begin
            // The unused request code leaves the queue as it is.
         end
      endcase
   end

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         capacity_ff  <= DEPTH_CNT;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            // A new capacity starts an empty queue; slot contents stay.
            capacity_ff <= csr_capacity;
            head_ff     <= '0;
            count_ff    <= '0;
         end else if (advance) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_type_ff <= req_type;
         in_msg_ff  <= req_message;
      end
      if (advance) begin
         status_ff <= status_in;
         fill_ff   <= count_in;
         rd_sel_ff <= rd_sel_in;
      end
   end

   mrq_slot_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (MESSAGE_WIDTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_msg_ff),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_fill_count   = fill_ff;
   assign rsp_read_message = rd_sel_ff ? ram_rd_data : '0;

endmodule

// ===== sim/mrq_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Message ring queue checking package
// A mirror of the slot ring that predicts each reply and checks the replies
// that come back from the queue.
// ----------------------------------------------------------------------------
package mrq_tb_pkg;

   localparam int DEPTH  = mrq_pkg::QUEUE_DEPTH_DEF;
   localparam int MSG_W  = mrq_pkg::MESSAGE_WIDTH_DEF;
   localparam int FILL_W = $clog2(mrq_pkg::QUEUE_DEPTH_DEF + 1);

   // Request code that the queue must ignore.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      mrq_pkg::status_code_type status;
      logic [MSG_W-1:0]         read_message;
      logic [FILL_W-1:0]        fill_count;
   } queue_reply_type;

   class ring_queue_mirror;
      logic [MSG_W-1:0] slot_words [DEPTH];
      int unsigned      head_slot;
      int unsigned      fill;
      int unsigned      ring_size;
      int unsigned      failures;
      queue_reply_type  awaited_replies [$];

      function new();
         head_slot = 0;
         fill      = 0;
         ring_size = DEPTH;
         failures  = 0;
      endfunction

      // A capacity write also empties the queue; slot words stay.
      function void load_capacity(logic [FILL_W-1:0] value);
         if (value == 0)
            ring_size = 1;
         else if (value > DEPTH)
            ring_size = DEPTH;
         else
            ring_size = 32'(value);
         head_slot = 0;
         fill      = 0;
      endfunction

      function void take_request(logic [1:0] kind, logic [MSG_W-1:0] msg);
         queue_reply_type reply;
         int unsigned     tail_slot;
         reply.status       = mrq_pkg::STAT_DONE;
         reply.read_message = '0;
         case (kind)
            mrq_pkg::REQ_SEND, mrq_pkg::REQ_JAM: begin
               if (fill >= ring_size) begin
                  reply.status = mrq_pkg::STAT_FULL;
               end else if (kind == mrq_pkg::REQ_SEND) begin
                  tail_slot = head_slot + fill;
                  if (tail_slot >= ring_size)
                     tail_slot -= ring_size;
                  slot_words[tail_slot] = msg;
                  fill++;
               end else begin
                  head_slot = (head_slot == 0) ? ring_size - 1 : head_slot - 1;
                  slot_words[head_slot] = msg;
                  fill++;
               end
            end
            mrq_pkg::REQ_RECV: begin
               if (fill == 0) begin
                  reply.status = mrq_pkg::STAT_EMPTY;
               end else begin
                  reply.read_message = slot_words[head_slot];
                  head_slot++;
                  if (head_slot >= ring_size)
                     head_slot -= ring_size;
                  fill--;
               end
            end
            default: ;
         endcase
         reply.fill_count = fill[FILL_W-1:0];
         awaited_replies.insert(awaited_replies.size(), reply);
      endfunction

      function void check_reply(logic [1:0] status, logic [MSG_W-1:0] read_message,
                                logic [FILL_W-1:0] fill_count);
         queue_reply_type want;
         if (awaited_replies.size() == 0) begin
            $error("rsp: transaction with no prediction waiting (status %0d, fill %0d)",
                   status, fill_count);
            failures++;
            return;
         end
         want = awaited_replies.pop_front();
         if (status !== want.status) begin
            $error("rsp_status: expected %0d, actual %0d", want.status, status);
            failures++;
         end
         if (read_message !== want.read_message) begin
            $error("rsp_read_message: expected %h, actual %h",
                   want.read_message, read_message);
            failures++;
         end
         if (fill_count !== want.fill_count) begin
            $error("rsp_fill_count: expected %0d, actual %0d", want.fill_count, fill_count);
            failures++;
         end
      endfunction

      function int unsigned pending_count();
         return awaited_replies.size();
      endfunction

      function int unsigned fill_level();
         return fill;
      endfunction

      function int unsigned slots_in_use();
         return ring_size;
      endfunction

      function int unsigned failure_count();
         return failures;
      endfunction
   endclass

endpackage

// ===== sim/tb_message_ring_queue_with_jam_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Message ring queue with head insert: testbench
// Drives send, jam, receive and unused requests through the queue at several
// capacities, with random idle bursts on both channels and one long result
// hold-off, and checks every reply against a mirror of the slot ring.
// ----------------------------------------------------------------------------
module tb_message_ring_queue_with_jam_top;

   localparam int DEPTH  = mrq_tb_pkg::DEPTH;
   localparam int MSG_W  = mrq_tb_pkg::MSG_W;
   localparam int FILL_W = mrq_tb_pkg::FILL_W;

   // The run is cut off here; the slowest correct run needs far fewer cycles.
   localparam int unsigned CYCLE_LIMIT      = 200000;
   // Number of cycles the result side is held off once to back up the queue.
   localparam int unsigned LONG_HOLD_CYCLES = 80;
   // Settling time after the last reply.
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned RANDOM_PHASES    = 10;
   localparam int unsigned ITEMS_PER_PHASE  = 95;

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic              req_stall;
   logic [1:0]        req_type     = 2'd0;
   logic [MSG_W-1:0]  req_message  = '0;
   logic              rsp_valid;
   logic              rsp_stall    = 1'b0;
   logic [1:0]        rsp_status;
   logic [MSG_W-1:0]  rsp_read_message;
   logic [FILL_W-1:0] rsp_fill_count;
   logic              csr_valid    = 1'b0;
   logic              csr_ready;
   logic [FILL_W-1:0] csr_capacity = '0;

   // Knobs shared between the request sequence and the result side.
   int unsigned gap_pct       = 0;
   int unsigned stall_pct     = 0;
   bit          quiet_tail    = 1'b0;
   bit          long_hold_due = 1'b0;
   int unsigned cycle_count   = 0;

   mrq_tb_pkg::ring_queue_mirror mirror = new();

   message_ring_queue_with_jam_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_message      (req_message),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_read_message (rsp_read_message),
      .rsp_fill_count   (rsp_fill_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_capacity     (csr_capacity)
   );

   always #4 clock = ~clock;

   // Watchdog. A hung handshake ends the run here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Every reply transaction taken at a rising edge is checked against the
   // oldest prediction. Outputs are read before the edge updates them.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         mirror.check_reply(rsp_status, rsp_read_message, rsp_fill_count);
   end

   // Result side. It alternates random runs of stalling and taking replies,
   // with the stall share set per phase. Once, on request, it stalls for a
   // long stretch so that the queue's output and input registers fill and
   // req_stall rises while requests keep coming. During the last phase it
   // never stalls.
   initial begin
      wait (!reset);
      @(negedge clock);
      forever begin
         if (long_hold_due && !quiet_tail) begin
            long_hold_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else if (!quiet_tail && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   end

   // Offers one request transaction, possibly after an idle burst, and holds
   // the payload until the queue takes it. Called and returning at a falling
   // edge, so req_valid stays high between back-to-back transactions.
   task automatic push_request(input logic [1:0] kind, input logic [MSG_W-1:0] msg);
      if (!quiet_tail && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_message <= msg;
      do @(posedge clock); while (req_stall);
      mirror.take_request(kind, msg);
      @(negedge clock);
   endtask

   // Lets every outstanding reply come back, then writes the capacity
   // register. Since every request yields exactly one reply, an empty
   // prediction store means the queue is idle.
   task automatic reshape_queue(input logic [FILL_W-1:0] value);
      req_valid <= 1'b0;
      while (mirror.pending_count() != 0) @(negedge clock);
      csr_valid    <= 1'b1;
      csr_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      mirror.load_capacity(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random request mix. The stream leans toward filling until the queue is
   // full and toward draining until it is empty, so both rejections and wrap
   // of head and tail come up often. A small share uses the unused code.
   task automatic random_phase(input int unsigned count, input int unsigned hold_at);
      bit          leaning_fill;
      int unsigned roll;
      logic [1:0]  kind;
      logic [MSG_W-1:0] msg;
      leaning_fill = 1'b1;
      for (int unsigned n = 0; n < count; n++) begin
         if (n == hold_at)
            long_hold_due = 1'b1;
         if (mirror.fill_level() >= mirror.slots_in_use())
            leaning_fill = 1'b0;
         else if (mirror.fill_level() == 0)
            leaning_fill = 1'b1;
         else if ($urandom_range(99) < 4)
            leaning_fill = !leaning_fill;
         roll = $urandom_range(99);
         if (roll < 3)
            kind = mrq_tb_pkg::REQ_UNUSED;
         else if ((roll < 78) == leaning_fill)
            kind = $urandom_range(1) ? mrq_pkg::REQ_SEND : mrq_pkg::REQ_JAM;
         else
            kind = mrq_pkg::REQ_RECV;
         case ($urandom_range(9))
            0:       msg = '0;
            1:       msg = '1;
            default: msg = $urandom;
         endcase
         push_request(kind, msg);
      end
   endtask

   initial begin
      logic [FILL_W-1:0] phase_capacity [RANDOM_PHASES];
      phase_capacity = '{5'd16, 5'd1, 5'd31, 5'd17, 5'd0, 5'd3, 5'd0, 5'd8, 5'd2, 5'd16};
      // Two of the phases take a random legal capacity.
      phase_capacity[4] = FILL_W'($urandom_range(1, DEPTH));
      phase_capacity[7] = FILL_W'($urandom_range(1, DEPTH));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, first at the capacity left by reset. A receive on the
      // empty queue, the unused code, extreme messages, and a jam with the
      // head at slot zero so that it wraps to the top slot.
      gap_pct   = 30;
      stall_pct = 30;
      push_request(mrq_pkg::REQ_RECV, 32'h1234_5678);
      push_request(mrq_tb_pkg::REQ_UNUSED, 32'h5A5A_5A5A);
      push_request(mrq_pkg::REQ_SEND, '0);
      push_request(mrq_pkg::REQ_SEND, '1);
      push_request(mrq_pkg::REQ_JAM, 32'hA5A5_A5A5);
      push_request(mrq_tb_pkg::REQ_UNUSED, '1);
      push_request(mrq_pkg::REQ_RECV, '0);
      push_request(mrq_pkg::REQ_RECV, '1);
      push_request(mrq_pkg::REQ_RECV, 32'h0F0F_0F0F);
      push_request(mrq_pkg::REQ_RECV, '0);

      // Two slots: tail wrap on send, send and jam both rejected when full,
      // and a jam that lands behind a wrapped head.
      reshape_queue(5'd2);
      push_request(mrq_pkg::REQ_JAM, 32'h0000_0001);
      push_request(mrq_pkg::REQ_SEND, 32'h0000_0002);
      push_request(mrq_pkg::REQ_SEND, 32'h0000_0003);
      push_request(mrq_pkg::REQ_JAM, 32'h0000_0004);
      push_request(mrq_pkg::REQ_RECV, '0);
      push_request(mrq_pkg::REQ_JAM, 32'h0000_0005);
      push_request(mrq_pkg::REQ_RECV, '0);
      push_request(mrq_pkg::REQ_RECV, '0);
      push_request(mrq_pkg::REQ_RECV, '0);

      // A capacity of zero must behave as a single slot.
      reshape_queue(5'd0);
      push_request(mrq_pkg::REQ_SEND, 32'hDEAD_BEEF);
      push_request(mrq_pkg::REQ_JAM, 32'hCAFE_F00D);
      push_request(mrq_pkg::REQ_RECV, '1);
      push_request(mrq_pkg::REQ_RECV, '1);

      // Random phases, each at its own capacity and idle mix. Out-of-range
      // values (above the built depth, and zero) are among them. The long
      // result hold-off falls in the first phase, and the last phase runs
      // with no idling on either side.
      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         reshape_queue(phase_capacity[p]);
         if (p == RANDOM_PHASES - 1) begin
            quiet_tail = 1'b1;
            gap_pct    = 0;
            stall_pct  = 0;
         end else begin
            gap_pct   = 25 * $urandom_range(0, 2);
            stall_pct = 25 * $urandom_range(0, 2);
         end
         random_phase(ITEMS_PER_PHASE, (p == 0) ? 40 : ITEMS_PER_PHASE);
      end

      // Wait for the last replies, then a little longer to catch any stray one.
      req_valid <= 1'b0;
      while (mirror.pending_count() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mirror.failure_count() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
